@@ rtl/zst_pkg.sv @@
`timescale 1ns / 1ps
package zst_pkg;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IDX_WIDTH   = 2'd0;
  localparam cfg_idx_t CFG_IDX_HEIGHT  = 2'd1;
  localparam cfg_idx_t CFG_IDX_SUBPASS = 2'd2;

  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 12;
  localparam int ROW_BITS    = 12;
  localparam int PEND_BITS   = 11;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [PEND_BITS-1:0]   PEND_MAX     = 11'h7FF;

  localparam int MIN_SIZE      = 4;
  localparam int MAX_WIDTH_DEF = 1024;

  // neighbor count limits for a removable pixel
  localparam logic [3:0] NB_MIN = 4'd2;
  localparam logic [3:0] NB_MAX = 4'd6;

  typedef logic [8:0] window_t;

endpackage

@@ rtl/zst_in_if.sv @@
`timescale 1ns / 1ps
interface zst_in_if;
  logic valid;
  logic ready;
  logic in_pixel;
  logic drain;

  modport source (output valid, output in_pixel, output drain, input ready);
  modport sink   (input valid, input in_pixel, input drain, output ready);
endinterface

@@ rtl/zst_out_if.sv @@
`timescale 1ns / 1ps
interface zst_out_if;
  logic valid;
  logic ready;
  logic out_pixel;
  logic removed;
  logic frame_last;

  modport source (output valid, output out_pixel, output removed, output frame_last,
                  input ready);
  modport sink   (input valid, input out_pixel, input removed, input frame_last,
                  output ready);
endinterface

@@ rtl/zst_line_store.sv @@
`timescale 1ns / 1ps
module zst_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr_a,
  output logic          rdata_a,
  input  logic [AW-1:0] raddr_b,
  output logic          rdata_b
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // port A never reads the column being written
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
  end

  // port B forwards a same-cycle write
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr_b)) begin
      rdata_b <= wdata;
    end else begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/zst_decide.sv @@
`timescale 1ns / 1ps
module zst_decide (
  input  zst_pkg::window_t win,
  input  logic             sub_pass,
  output logic             clear
);
  import zst_pkg::*;

  logic [7:0] ring;
  logic [7:0] rise;
  logic [3:0] trans;
  logic [3:0] count;
  logic       p1;
  logic       p2;
  logic       n, e, s, w;

  assign n = win[1];
  assign e = win[5];
  assign s = win[7];
  assign w = win[3];

  // clockwise from north: N NE E SE S SW W NW
  assign ring = {win[0], win[3], win[6], win[7], win[8], win[5], win[2], win[1]};
  assign rise = ~ring & {ring[0], ring[7:1]};

  always_comb begin
    trans = 4'($countones(rise));
    count = 4'($countones(ring));
    if (sub_pass) begin
      p1 = n & e & w;
      p2 = n & s & w;
    end else begin
      p1 = n & e & s;
      p2 = e & s & w;
    end
    clear = win[4] && (trans == 4'd1) && (count >= NB_MIN) && (count <= NB_MAX)
            && !p1 && !p2;
  end

endmodule

@@ rtl/zhang_suen_thinning_pass.sv @@
`timescale 1ns / 1ps
// channel   dir  payload                          beat when
// in_ch     in   in_pixel, drain                  valid && ready
// out_ch    out  out_pixel, removed, frame_last   valid && ready
// cfg       in   cfg_index, cfg_data              cfg_wr_en
//
// One pixel beat per clock while out_ch is not stalled. A result shows on
// out_ch in the cycle after the beat that causes it; the output register is the single
// register stage between line-store read data and out_ch.
// Line stores are read one column ahead, so stalls on either side cost nothing.
// rst clears counters, window and out valid and sets config to its defaults; line stores are not cleared.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
module zhang_suen_thinning_pass #(
  parameter int MAX_WIDTH = zst_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  zst_pkg::cfg_idx_t                 cfg_index,
  input  logic [zst_pkg::CFG_DATA_BITS-1:0] cfg_data,
  zst_in_if.sink                            in_ch,
  zst_out_if.source                         out_ch
);
  import zst_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int DW = (WW > PEND_BITS) ? WW : PEND_BITS;

  function automatic logic [WW-1:0] eff_width(input logic [WIDTH_BITS-1:0] raw);
    logic [WW-1:0] res;
    if (raw < MIN_SIZE) begin
      res = WW'(MIN_SIZE);
    end else if (raw > MAX_WIDTH) begin
      res = WW'(MAX_WIDTH);
    end else begin
      res = WW'(raw);
    end
    return res;
  endfunction

  logic [WIDTH_BITS-1:0]  image_width, image_width_next;
  logic [HEIGHT_BITS-1:0] image_height;
  logic                   sub_pass;

  logic [ROW_BITS-1:0]  in_row, in_row_next;
  logic [CW-1:0]        in_column, in_column_next;
  logic [PEND_BITS-1:0] pending, pending_next, pend_base;
  window_t              window, window_next, win_new;

  logic [WW-1:0]          eff_w, eff_w_next, col_inc, up_diff;
  logic [HEIGHT_BITS-1:0] eff_h;
  logic [ROW_BITS-1:0]    row_inc;
  logic [DW-1:0]          mid_diff;

  logic accept, first_px, drain_ok, pend_high, interior, clear;
  logic px_main, px_edge;
  logic up_rd, mid_rd, up_b, mid_b;
  logic res_valid, res_pixel, res_removed, res_last;

  assign eff_w = eff_width(image_width);
  assign eff_h = (image_height < MIN_SIZE) ? HEIGHT_BITS'(MIN_SIZE) : image_height;

  assign image_width_next = (cfg_wr_en && (cfg_index == CFG_IDX_WIDTH))
                            ? cfg_data[WIDTH_BITS-1:0] : image_width;
  assign eff_w_next = eff_width(image_width_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      sub_pass     <= 1'b0;
    end else begin
      image_width <= image_width_next;
      if (cfg_wr_en && (cfg_index == CFG_IDX_HEIGHT)) begin
        image_height <= cfg_data[HEIGHT_BITS-1:0];
      end
      if (cfg_wr_en && (cfg_index == CFG_IDX_SUBPASS)) begin
        sub_pass <= cfg_data[0];
      end
    end
  end

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign win_new = {in_ch.in_pixel, window[8:7], mid_rd, window[5:4], up_rd, window[2:1]};

  zst_decide u_decide (
    .win      (win_new),
    .sub_pass (sub_pass),
    .clear    (clear)
  );

  always_comb begin
    col_inc   = WW'(in_column) + WW'(1);
    row_inc   = in_row + ROW_BITS'(1);
    first_px  = (in_row == '0) && (in_column == '0);
    pend_base = first_px ? '0 : pending;
    drain_ok  = first_px && (pending != '0);
    pend_high = DW'(pending) > DW'(eff_w);
    px_main   = (in_column != '0) && (in_row != '0);
    px_edge   = (in_column == '0) && (in_row >= ROW_BITS'(2));
    interior  = (in_row >= ROW_BITS'(2)) && (in_column >= CW'(2))
                && (in_row < eff_h) && (WW'(in_column) < eff_w);

    in_row_next    = in_row;
    in_column_next = in_column;
    pending_next   = pending;
    window_next    = window;
    res_valid      = 1'b0;
    res_pixel      = 1'b0;
    res_removed    = 1'b0;
    res_last       = 1'b0;

    if (accept) begin
      if (in_ch.drain) begin
        if (drain_ok) begin
          res_valid    = 1'b1;
          res_pixel    = pend_high ? up_b : mid_b;
          res_last     = (pending == PEND_BITS'(1));
          pending_next = pending - PEND_BITS'(1);
        end
      end else begin
        window_next  = win_new;
        pending_next = pend_base;
        priority if (px_main) begin
          res_valid   = 1'b1;
          res_removed = interior && clear;
          res_pixel   = (interior && clear) ? 1'b0 : win_new[4];
        end else if (px_edge) begin
          // right border pixel: east cell of the previous row's last window
          res_valid = 1'b1;
          res_pixel = window[5];
        end else if (pend_base != PEND_MAX) begin
          pending_next = pend_base + PEND_BITS'(1);
        end
        if (col_inc >= eff_w) begin
          in_column_next = '0;
          in_row_next    = (row_inc >= eff_h) ? '0 : row_inc;
        end else begin
          in_column_next = col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row    <= '0;
      in_column <= '0;
      pending   <= '0;
      window    <= '0;
    end else begin
      in_row    <= in_row_next;
      in_column <= in_column_next;
      pending   <= pending_next;
      window    <= window_next;
    end
  end

  // drain read addresses follow the next pending count and width
  assign up_diff  = eff_w_next - WW'(1);
  assign mid_diff = DW'(eff_w_next) - DW'(pending_next);

  zst_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
    .clk     (clk),
    .we      (accept && !in_ch.drain),
    .waddr   (in_column),
    .wdata   (mid_rd),
    .raddr_a (in_column_next),
    .rdata_a (up_rd),
    .raddr_b (up_diff[CW-1:0]),
    .rdata_b (up_b)
  );

  zst_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_middle (
    .clk     (clk),
    .we      (accept && !in_ch.drain),
    .waddr   (in_column),
    .wdata   (in_ch.in_pixel),
    .raddr_a (in_column_next),
    .rdata_a (mid_rd),
    .raddr_b (mid_diff[CW-1:0]),
    .rdata_b (mid_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (res_valid) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_ch.out_pixel  <= res_pixel;
      out_ch.removed    <= res_removed;
      out_ch.frame_last <= res_last;
    end
  end

  // an ignored drain beat adds no result on the output side
  a_drain_ignored: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.drain && !drain_ok)
    |=> (out_ch.valid == $past(out_ch.valid && !out_ch.ready)))
    else $error("ignored drain beat produced a result");

  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.drain && drain_ok && (pending == PEND_BITS'(1)))
    |=> ((pending == '0) && out_ch.valid && out_ch.frame_last))
    else $error("last drain beat did not close the frame");

  a_pixel_not_last: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_ch.drain) |=> !(out_ch.valid && out_ch.frame_last))
    else $error("pixel beat flagged as frame end");

endmodule

@@ verif/zst_checker.sv @@
`timescale 1ns / 1ps
module zst_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  zst_pkg::cfg_idx_t                 cfg_index,
  input  logic [zst_pkg::CFG_DATA_BITS-1:0] cfg_data,
  zst_in_if                                 in_ch,
  zst_out_if                                out_ch,
  output int unsigned                       fail_count,
  output int unsigned                       owed
);
  import zst_pkg::*;

  localparam int unsigned MAX_W = MAX_WIDTH_DEF;

  typedef struct packed {
    logic out_pixel;
    logic removed;
    logic frame_last;
  } thin_result_t;

  // two previous image rows and the sliding 3x3 neighborhood
  logic    prev2_line [MAX_W];
  logic    prev1_line [MAX_W];
  window_t nbhd;
  int unsigned pos_row;
  int unsigned pos_col;
  int unsigned backlog;

  logic [WIDTH_BITS-1:0]  w_reg;
  logic [HEIGHT_BITS-1:0] h_reg;
  logic                   sp_reg;

  thin_result_t due_q[$];
  thin_result_t want;
  int unsigned  errs    = 0;
  int unsigned  owed_n  = 0;

  assign fail_count = errs;
  assign owed       = owed_n;

  function automatic bit is_removable(window_t nb, logic sp);
    logic n, ne, e, se, s, sw, w, nw;
    logic ring [9];
    int unsigned rises;
    int unsigned cnt;
    bit no_corner;
    n  = nb[1]; ne = nb[2]; e  = nb[5]; se = nb[8];
    s  = nb[7]; sw = nb[6]; w  = nb[3]; nw = nb[0];
    ring = '{n, ne, e, se, s, sw, w, nw, n};
    rises = 0;
    for (int k = 0; k < 8; k++) if (!ring[k] && ring[k + 1]) rises++;
    cnt = $countones({n, ne, e, se, s, sw, w, nw});
    if (!sp) no_corner = !(n & e & s) && !(e & s & w);
    else     no_corner = !(n & e & w) && !(n & s & w);
    return nb[4] && rises == 1 && cnt >= NB_MIN && cnt <= NB_MAX && no_corner;
  endfunction

  function automatic void thin_beat(logic pix, logic drn);
    int unsigned wd, ht, r, c, ci;
    logic up, mid, old_e;
    bit interior;
    thin_result_t res;
    wd = w_reg;
    if (wd < MIN_SIZE) wd = MIN_SIZE;
    if (wd > MAX_W) wd = MAX_W;
    ht = (h_reg < MIN_SIZE) ? MIN_SIZE : h_reg;
    r = pos_row;
    c = pos_col;

    if (drn) begin
      // only counts right at a frame boundary with something still owed
      if (r != 0 || c != 0 || backlog == 0) return;
      res.out_pixel  = (backlog > wd) ? prev2_line[wd - 1] : prev1_line[wd - backlog];
      res.removed    = 1'b0;
      res.frame_last = (backlog == 1);
      due_q.push_back(res);
      backlog--;
      return;
    end

    if (r == 0 && c == 0) backlog = 0;
    ci    = (c < MAX_W) ? c : MAX_W - 1;
    old_e = nbhd[5];
    up    = prev2_line[ci];
    mid   = prev1_line[ci];
    nbhd  = {pix, nbhd[8:7], mid, nbhd[5:4], up, nbhd[2:1]};
    prev2_line[ci] = mid;
    prev1_line[ci] = pix;

    if (c >= 1 && r >= 1) begin
      interior = r >= 2 && c >= 2 && r - 1 <= ht - 2 && c - 1 <= wd - 2;
      if (interior && is_removable(nbhd, sp_reg)) res = '{1'b0, 1'b1, 1'b0};
      else res = '{nbhd[4], 1'b0, 1'b0};
      due_q.push_back(res);
    end else if (c == 0 && r >= 2) begin
      // last column of the row above comes out on the next row's first beat
      res = '{old_e, 1'b0, 1'b0};
      due_q.push_back(res);
    end else if (backlog < PEND_MAX) begin
      backlog++;
    end

    if (c + 1 >= wd) begin
      pos_col = 0;
      pos_row = (r + 1 >= ht) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      nbhd    = '0;
      pos_row = 0;
      pos_col = 0;
      backlog = 0;
      w_reg   = WIDTH_RESET;
      h_reg   = HEIGHT_RESET;
      sp_reg  = 1'b0;
      due_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          $error("result beat with none due: out_pixel=%0b removed=%0b frame_last=%0b",
                 out_ch.out_pixel, out_ch.removed, out_ch.frame_last);
          errs++;
        end else begin
          want = due_q.pop_front();
          if (out_ch.out_pixel !== want.out_pixel) begin
            $error("out_pixel: expected %0b, got %0b", want.out_pixel, out_ch.out_pixel);
            errs++;
          end
          if (out_ch.removed !== want.removed) begin
            $error("removed: expected %0b, got %0b", want.removed, out_ch.removed);
            errs++;
          end
          if (out_ch.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last, out_ch.frame_last);
            errs++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) thin_beat(in_ch.in_pixel, in_ch.drain);
      // a register write takes effect after any beat on the same edge
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IDX_WIDTH:   w_reg  = cfg_data[WIDTH_BITS-1:0];
          CFG_IDX_HEIGHT:  h_reg  = cfg_data[HEIGHT_BITS-1:0];
          CFG_IDX_SUBPASS: sp_reg = cfg_data[0];
          default: ;
        endcase
      end
    end
    owed_n = due_q.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import zst_pkg::*;

  localparam cfg_idx_t    CFG_IDX_SPARE = 2'd3;
  localparam int unsigned RAND_ITEMS    = 1800;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 4000;
  // 4x4 frame, first row in the top nibble
  localparam logic [15:0] SMALL_IMG     = 16'b0110_1111_1110_0100;

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  cfg_idx_t                 cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  zst_in_if  in_ch ();
  zst_out_if out_ch ();

  int unsigned chk_fails;
  int unsigned owed;
  int unsigned idle_cycles = 0;
  int unsigned send_gap_pct = 12;
  int unsigned recv_gap_pct = 45;
  int unsigned frame_w = 4;
  int unsigned frame_h = 4;
  int unsigned rand_items = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  zhang_suen_thinning_pass i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  zst_checker i_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (chk_fails),
    .owed       (owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // result side: random back-pressure plus one long hold while pixels keep coming
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  task automatic put_beat(input logic pix, input logic drn);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_pixel <= pix;
    in_ch.drain    <= drn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rand_items++;
  endtask

  // n pixels; now and then an in-frame drain that the block must ignore
  task automatic put_pixels(input int unsigned n, input int unsigned dens);
    for (int unsigned i = 0; i < n; i++) begin
      put_beat($urandom_range(99) < dens, 1'b0);
      if (i + 1 < n && $urandom_range(99) < 3) put_beat(1'($urandom_range(1)), 1'b1);
    end
  endtask

  task automatic put_drains(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) put_beat(1'($urandom_range(1)), 1'b1);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [11:0] w_raw, input logic [11:0] h_raw,
                            input logic [11:0] sp_raw, input bit spare);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data  <= w_raw;
    @(posedge clk);
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data  <= h_raw;
    @(posedge clk);
    cfg_index <= CFG_IDX_SUBPASS;
    cfg_data  <= sp_raw;
    @(posedge clk);
    if (spare) begin
      cfg_index <= CFG_IDX_SPARE;
      cfg_data  <= CFG_DATA_BITS'($urandom);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    frame_w = w_raw[WIDTH_BITS-1:0];
    if (frame_w < MIN_SIZE) frame_w = MIN_SIZE;
    if (frame_w > MAX_WIDTH_DEF) frame_w = MAX_WIDTH_DEF;
    frame_h = (h_raw < MIN_SIZE) ? MIN_SIZE : h_raw;
  endtask

  task automatic random_frame(input bit reconfig);
    logic [11:0] w_raw;
    logic [11:0] h_raw;
    int unsigned dens;
    int unsigned n_drain;
    if (reconfig) begin
      case ($urandom_range(9))
        0:       w_raw = 12'($urandom_range(0, 3));
        1:       w_raw = 12'h800 | 12'($urandom_range(4, 10));
        2:       w_raw = 12'($urandom_range(15, 32));
        default: w_raw = 12'($urandom_range(4, 14));
      endcase
      case ($urandom_range(9))
        0:       h_raw = 12'($urandom_range(0, 3));
        1:       h_raw = 12'($urandom_range(11, 16));
        default: h_raw = 12'($urandom_range(4, 10));
      endcase
      settle();
      write_regs(w_raw, h_raw, 12'($urandom), $urandom_range(3) == 0);
    end
    case ($urandom_range(3))
      0:       dens = 10;
      1:       dens = 40;
      2:       dens = 65;
      default: dens = 85;
    endcase
    put_pixels(frame_w * frame_h, dens);
    // none: next frame drops what is owed; some; all plus a few with nothing owed
    case ($urandom_range(9))
      0, 1, 2: n_drain = 0;
      3, 4, 5: n_drain = $urandom_range(1, frame_w);
      default: n_drain = frame_w + 1 + $urandom_range(2);
    endcase
    put_drains(n_drain);
  endtask

  // very tall frame, cut short by a height write partway down
  task automatic tall_frame();
    logic [11:0] sp;
    sp = 12'($urandom);
    settle();
    write_regs(12'd4, 12'd4095, sp, 1'b0);
    put_pixels(40, 50);
    settle();
    write_regs(12'd4, 12'd12, sp, 1'b0);
    put_pixels(8, 50);
    put_drains(frame_w + 1);
  endtask

  // width shrinks mid-row and sub-pass flips; more is owed than width+1 at the end
  task automatic narrowing_frame();
    logic [11:0] sp;
    sp = 12'($urandom);
    settle();
    write_regs(12'd16, 12'd8, sp, 1'b0);
    put_pixels(53, 60);
    settle();
    write_regs(12'd9, 12'd8, sp ^ 12'd1, 1'b1);
    put_pixels(40, 60);
    put_drains(17);
  endtask

  // one full row at the clamped width, long hold once results start, then the
  // width drops to 4 a few columns into the second row
  task automatic widest_frame();
    logic [11:0] sp;
    sp = 12'($urandom);
    settle();
    write_regs(12'h7FF, 12'd3, sp, 1'b1);
    put_pixels(frame_w, 50);
    hold_req = 1'b1;
    put_pixels(6, 50);
    settle();
    write_regs(12'd4, 12'd4, sp, 1'b0);
    put_pixels(9, 50);
    put_drains(frame_w + 1);
  endtask

  initial begin
    int unsigned frame_no;
    rst            <= 1'b1;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= CFG_IDX_WIDTH;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.in_pixel <= 1'b0;
    in_ch.drain    <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // clamped 4x4 frame; stray drains before it and inside it
    write_regs(12'd2, 12'd1, 12'd0, 1'b1);
    put_beat(1'b1, 1'b1);
    for (int i = 0; i < 16; i++) begin
      put_beat(SMALL_IMG[15 - i], 1'b0);
      if (i == 6) put_beat(1'b0, 1'b1);
    end
    put_drains(3);

    frame_no = 0;
    while (rand_items < RAND_ITEMS) begin
      if (rand_items < RAND_ITEMS / 3) begin
        send_gap_pct = 12;
        recv_gap_pct = 45;
      end else if (rand_items < 2 * RAND_ITEMS / 3) begin
        send_gap_pct = 45;
        recv_gap_pct = 12;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      case (frame_no)
        0:       widest_frame();
        1:       tall_frame();
        2:       narrowing_frame();
        default: random_frame($urandom_range(1) == 1);
      endcase
      frame_no++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (chk_fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
